FILE: hw/rtl/nps_pkg.sv
package nps_pkg;

  localparam int NOTES    = 128;
  localparam int MAX_READ = 64;

  // Fixed field widths of the stream items
  localparam int FIELD_W  = 7;
  localparam int CMD_W    = 2;

  localparam int NOTE_W   = $clog2(NOTES);
  localparam int LINK_W   = $clog2(NOTES + 1);
  localparam int CNT_W    = $clog2(MAX_READ + 1);

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NOTES);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_ENTRY  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [FIELD_W-1:0] note_out;
    logic [FIELD_W-1:0] top_velocity;
    logic               empty_res;
    logic               last;
  } res_t;

endpackage

FILE: hw/rtl/nps_ram.sv
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/nps_ctrl.sv
module nps_ctrl
  import nps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   in_cmd_i,
  input  logic [FIELD_W-1:0] in_note_i,
  input  logic [FIELD_W-1:0] in_vel_i,
  input  logic [FIELD_W-1:0] in_count_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UNLINK,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_STAT_RD,
    ST_STAT_LD,
    ST_STAT_OUT,
    ST_LIST_RD,
    ST_LIST_OUT
  } state_e;

  state_e             state_q, state_d;
  cmd_e               cmd_q, cmd_d;
  logic [LINK_W-1:0]  note_q, note_d;
  logic [FIELD_W-1:0] vel_q, vel_d;
  logic [CNT_W-1:0]   limit_q, limit_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LINK_W-1:0]  cur_q, cur_d;
  logic [LINK_W-1:0]  top_q, top_d;
  logic [FIELD_W-1:0] topvel_q, topvel_d;
  logic [NOTES-1:0]   held_q, held_d;

  logic               up_we, up_re, dn_we, dn_re, vel_we, vel_re;
  logic [NOTE_W-1:0]  up_waddr, up_raddr, dn_waddr, dn_raddr, vel_waddr, vel_raddr;
  logic [LINK_W-1:0]  up_wdata, up_rdata, dn_wdata, dn_rdata;
  logic [FIELD_W-1:0] vel_wdata, vel_rdata;

  logic [LINK_W-1:0]  in_link;
  logic               in_ok;
  logic               top_ok;
  logic [NOTE_W-1:0]  note_idx;
  logic               list_last;

  nps_ram #(.WIDTH(LINK_W), .DEPTH(NOTES)) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (up_waddr),
    .wdata_i (up_wdata),
    .re_i    (up_re),
    .raddr_i (up_raddr),
    .rdata_o (up_rdata)
  );

  nps_ram #(.WIDTH(LINK_W), .DEPTH(NOTES)) u_dn_ram (
    .clk_i   (clk_i),
    .we_i    (dn_we),
    .waddr_i (dn_waddr),
    .wdata_i (dn_wdata),
    .re_i    (dn_re),
    .raddr_i (dn_raddr),
    .rdata_o (dn_rdata)
  );

  nps_ram #(.WIDTH(FIELD_W), .DEPTH(NOTES)) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (vel_we),
    .waddr_i (vel_waddr),
    .wdata_i (vel_wdata),
    .re_i    (vel_re),
    .raddr_i (vel_raddr),
    .rdata_o (vel_rdata)
  );

  assign in_link   = LINK_W'(in_note_i);
  assign in_ok     = in_link < NONE_LINK;
  assign top_ok    = top_q < NONE_LINK;
  assign note_idx  = note_q[NOTE_W-1:0];
  assign list_last = ((cnt_q + CNT_W'(1)) >= limit_q) || !(dn_rdata < NONE_LINK);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    note_d   = note_q;
    vel_d    = vel_q;
    limit_d  = limit_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    top_d    = top_q;
    topvel_d = topvel_q;
    held_d   = held_q;

    up_we     = 1'b0;
    up_waddr  = '0;
    up_wdata  = '0;
    up_re     = 1'b0;
    up_raddr  = '0;
    dn_we     = 1'b0;
    dn_waddr  = '0;
    dn_wdata  = '0;
    dn_re     = 1'b0;
    dn_raddr  = '0;
    vel_we    = 1'b0;
    vel_waddr = '0;
    vel_wdata = '0;
    vel_re    = 1'b0;
    vel_raddr = '0;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = cmd_e'(in_cmd_i);
          note_d  = in_link;
          vel_d   = in_vel_i;
          limit_d = (in_count_i > FIELD_W'(MAX_READ)) ? CNT_W'(MAX_READ)
                                                       : CNT_W'(in_count_i);
          // fetch both links of a held note so it can be unlinked next cycle
          up_raddr = in_link[NOTE_W-1:0];
          dn_raddr = in_link[NOTE_W-1:0];
          case (cmd_e'(in_cmd_i))
            CMD_PUSH: begin
              if (in_ok && held_q[in_link[NOTE_W-1:0]]) begin
                up_re   = 1'b1;
                dn_re   = 1'b1;
                state_d = ST_UNLINK;
              end else if (in_ok) begin
                state_d = ST_PUSH_A;
              end else begin
                state_d = ST_STAT_RD;
              end
            end
            CMD_REMOVE: begin
              if (in_ok && held_q[in_link[NOTE_W-1:0]]) begin
                up_re   = 1'b1;
                dn_re   = 1'b1;
                state_d = ST_UNLINK;
              end else begin
                state_d = ST_STAT_RD;
              end
            end
            CMD_CLEAR: begin
              held_d  = '0;
              top_d   = NONE_LINK;
              state_d = ST_STAT_RD;
            end
            default: begin
              state_d = ST_STAT_RD;
            end
          endcase
        end
      end

      ST_UNLINK: begin
        if (up_rdata < NONE_LINK) begin
          dn_we    = 1'b1;
          dn_waddr = up_rdata[NOTE_W-1:0];
          dn_wdata = dn_rdata;
        end
        if (dn_rdata < NONE_LINK) begin
          up_we    = 1'b1;
          up_waddr = dn_rdata[NOTE_W-1:0];
          up_wdata = up_rdata;
        end
        if (top_q == note_q) begin
          top_d = dn_rdata;
        end
        held_d[note_idx] = 1'b0;
        state_d = (cmd_q == CMD_PUSH) ? ST_PUSH_A : ST_STAT_RD;
      end

      ST_PUSH_A: begin
        vel_we    = 1'b1;
        vel_waddr = note_idx;
        vel_wdata = vel_q;
        dn_we     = 1'b1;
        dn_waddr  = note_idx;
        dn_wdata  = top_q;
        if (top_ok) begin
          up_we    = 1'b1;
          up_waddr = top_q[NOTE_W-1:0];
          up_wdata = note_q;
        end
        top_d            = note_q;
        held_d[note_idx] = 1'b1;
        state_d          = ST_PUSH_B;
      end

      ST_PUSH_B: begin
        up_we    = 1'b1;
        up_waddr = note_idx;
        up_wdata = NONE_LINK;
        state_d  = ST_STAT_RD;
      end

      ST_STAT_RD: begin
        vel_re    = 1'b1;
        vel_raddr = top_q[NOTE_W-1:0];
        state_d   = ST_STAT_LD;
      end

      ST_STAT_LD: begin
        topvel_d = top_ok ? vel_rdata : '0;
        cur_d    = top_q;
        cnt_d    = '0;
        if (cmd_q == CMD_READ && limit_q != '0 && top_ok) begin
          state_d = ST_LIST_RD;
        end else begin
          state_d = ST_STAT_OUT;
        end
      end

      ST_STAT_OUT: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_STATUS;
        res_o.note_out     = top_ok ? FIELD_W'(top_q) : '0;
        res_o.top_velocity = topvel_q;
        res_o.empty_res    = !top_ok;
        res_o.last         = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      ST_LIST_RD: begin
        dn_re    = 1'b1;
        dn_raddr = cur_q[NOTE_W-1:0];
        state_d  = ST_LIST_OUT;
      end

      ST_LIST_OUT: begin
        // the down link read in ST_LIST_RD stays in the RAM output until the next read
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_ENTRY;
        res_o.note_out     = FIELD_W'(cur_q);
        res_o.top_velocity = topvel_q;
        res_o.empty_res    = !top_ok;
        res_o.last         = list_last;
        if (res_ready_i) begin
          if (list_last) begin
            state_d = ST_IDLE;
          end else begin
            cur_d   = dn_rdata;
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = ST_LIST_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cmd_q    <= CMD_PUSH;
      note_q   <= '0;
      vel_q    <= '0;
      limit_q  <= '0;
      cnt_q    <= '0;
      cur_q    <= NONE_LINK;
      top_q    <= NONE_LINK;
      topvel_q <= '0;
      held_q   <= '0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      note_q   <= note_d;
      vel_q    <= vel_d;
      limit_q  <= limit_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      top_q    <= top_d;
      topvel_q <= topvel_d;
      held_q   <= held_d;
    end
  end

endmodule

FILE: hw/rtl/note_priority_stack.sv
// Last-note-priority stack of held notes.
// Slave stream: one command per transfer (push, remove, clear, read list).
// Master stream: status or listed-note results; tlast marks the final
// result of a command, tuser tells a status result (0) from a listed note (1).
// The links and velocities live in three one-port-read, one-port-write
// RAMs with registered read data; a sequencer walks each command through them
// one access step a cycle unless a result stalls, so one command is worked
// on at a time. Each command walks the states in order: a held note is
// first unlinked (remove, push of a held note), a pushed note is then linked
// on top, the top velocity is read, and then either the status result is
// sent or the list is walked, one down-link read per listed note.
// A new command is taken once the last result has left the sequencer, even
// while that result still waits in the output register.
// Reset empties the stack at once (held flags in flip-flops, top set to
// none); the RAMs are not cleared and need no clearing pass.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before the next result; no result is dropped.
module note_priority_stack
  import nps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // note[6:0], velocity[13:7], count[20:14], zeros
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // note_out[6:0], top_velocity[13:7], empty_res[14], 0
  output logic        m_axis_tuser_o,  // kind
  output logic        m_axis_tlast_o   // last
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_q;
  res_t out_q;

  nps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_note_i   (s_axis_tdata_i[6:0]),
    .in_vel_i    (s_axis_tdata_i[13:7]),
    .in_count_i  (s_axis_tdata_i[20:14]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.empty_res, out_q.top_velocity, out_q.note_out};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

endmodule

FILE: tb/note_priority_stack_tb.sv
module note_priority_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_CMDS = 480;
  localparam int unsigned CALM_CMDS   = 60;

  // Mirror of the held-note stack; computes the results each command causes.
  class stack_scoreboard;
    bit                held_q[NOTES];
    logic [LINK_W-1:0] up_q[NOTES];
    logic [LINK_W-1:0] down_q[NOTES];
    logic [FIELD_W-1:0] vel_q[NOTES];
    logic [LINK_W-1:0] top_q;
    int unsigned       held_cnt;
    res_t              expected_q[$];
    int unsigned       errors;

    function new();
      foreach (held_q[i]) begin
        held_q[i] = 1'b0;
        up_q[i]   = NONE_LINK;
        down_q[i] = NONE_LINK;
        vel_q[i]  = '0;
      end
      top_q    = NONE_LINK;
      held_cnt = 0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [FIELD_W-1:0] pick_held();
      int unsigned skip;
      skip = $urandom_range(0, held_cnt - 1);
      foreach (held_q[i]) begin
        if (held_q[i]) begin
          if (skip == 0) return FIELD_W'(i);
          skip--;
        end
      end
      return '0;
    endfunction

    function void unlink_note(int unsigned n);
      logic [LINK_W-1:0] u;
      logic [LINK_W-1:0] d;
      u = up_q[n];
      d = down_q[n];
      if (u < NOTES) down_q[u] = d;
      if (d < NOTES) up_q[d] = u;
      if (top_q == n) top_q = d;
      up_q[n]   = NONE_LINK;
      down_q[n] = NONE_LINK;
      held_q[n] = 1'b0;
      held_cnt--;
    endfunction

    function void note_command(cmd_e cmd, logic [FIELD_W-1:0] note,
                               logic [FIELD_W-1:0] velocity, logic [FIELD_W-1:0] count);
      res_t               r;
      bit                 is_empty;
      logic [FIELD_W-1:0] top_vel;
      int unsigned        lim;
      int unsigned        k;
      logic [LINK_W-1:0]  cur;
      logic [LINK_W-1:0]  nxt;
      case (cmd)
        CMD_PUSH: begin
          // a held note, even a lone top, is unlinked before it goes on top
          if (held_q[note]) unlink_note(note);
          vel_q[note]  = velocity;
          up_q[note]   = NONE_LINK;
          down_q[note] = top_q;
          if (top_q < NOTES) up_q[top_q] = LINK_W'(note);
          top_q        = LINK_W'(note);
          held_q[note] = 1'b1;
          held_cnt++;
        end
        CMD_REMOVE: begin
          if (held_q[note]) unlink_note(note);
        end
        CMD_CLEAR: begin
          foreach (held_q[i]) held_q[i] = 1'b0;
          held_cnt = 0;
          top_q    = NONE_LINK;
        end
        default: ;
      endcase
      is_empty = (top_q >= NOTES);
      top_vel  = is_empty ? '0 : vel_q[top_q];
      k = 0;
      if (cmd == CMD_READ) begin
        lim = (count > MAX_READ) ? MAX_READ : count;
        cur = top_q;
        while (k < lim && cur < NOTES) begin
          nxt            = down_q[cur];
          r.kind         = KIND_ENTRY;
          r.note_out     = cur[FIELD_W-1:0];
          r.top_velocity = top_vel;
          r.empty_res    = is_empty;
          r.last         = (k + 1 >= lim) || (nxt >= NOTES);
          expected_q.push_back(r);
          k++;
          cur = nxt;
        end
      end
      if (k == 0) begin
        r.kind         = KIND_STATUS;
        r.note_out     = is_empty ? '0 : top_q[FIELD_W-1:0];
        r.top_velocity = top_vel;
        r.empty_res    = is_empty;
        r.last         = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string field, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        $display("t=%0t unexpected result: expected none, actual kind %0d note %0d",
                 $time, got.kind, got.note_out);
        $display("  vel %0d empty %0d last %0d", got.top_velocity, got.empty_res, got.last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("kind", exp_r.kind, got.kind);
      compare_field("note_out", exp_r.note_out, got.note_out);
      compare_field("top_velocity", exp_r.top_velocity, got.top_velocity);
      compare_field("empty_res", exp_r.empty_res, got.empty_res);
      compare_field("last", exp_r.last, got.last);
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;  // note[6:0], velocity[13:7], count[20:14], zeros
  logic [1:0]  s_axis_tuser_i  = '0;  // command[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // note_out[6:0], top_velocity[13:7], empty_res[14], 0
  logic        m_axis_tuser_o;        // kind
  logic        m_axis_tlast_o;        // last

  stack_scoreboard sb = new();
  bit              tail_calm = 1'b0;
  int unsigned     cycle_cnt = 0;

  note_priority_stack i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind         = kind_e'(m_axis_tuser_o);
      got.note_out     = m_axis_tdata_o[6:0];
      got.top_velocity = m_axis_tdata_o[13:7];
      got.empty_res    = m_axis_tdata_o[14];
      got.last         = m_axis_tlast_o;
      sb.check_result(got);
    end
  end

  // Result backpressure: random stall bursts, none in the calm tail.
  initial begin
    wait (rst_ni);
    forever begin
      if (!tail_calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  task automatic send_cmd(cmd_e cmd, logic [6:0] note, logic [6:0] velocity,
                          logic [6:0] count);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, count, velocity, note};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(cmd, note, velocity, count);
  endtask

  task automatic idle_burst();
    s_axis_tvalid_i <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_cmd();
    int unsigned pick;
    cmd_e        cmd;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [6:0]  count;
    pick     = $urandom_range(0, 199);
    note     = $urandom_range(0, 127);
    velocity = $urandom_range(0, 127);
    count    = $urandom_range(1, 8);
    if (pick < 110) begin
      cmd = CMD_PUSH;
      if (sb.held_cnt > 0 && $urandom_range(0, 3) == 0) note = sb.pick_held();
    end else if (pick < 150) begin
      cmd = CMD_REMOVE;
      if (sb.held_cnt > 0 && $urandom_range(0, 3) != 0) note = sb.pick_held();
    end else if (pick < 199) begin
      cmd = CMD_READ;
      case ($urandom_range(0, 9))
        0:       count = $urandom_range(0, 127);
        1, 2:    count = $urandom_range(9, 64);
        default: ;
      endcase
    end else begin
      cmd = CMD_CLEAR;
    end
    send_cmd(cmd, note, velocity, count);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_READ,   7'd0,   7'd0,   7'd5);    // read of an empty stack
    send_cmd(CMD_PUSH,   7'd0,   7'd0,   7'd0);
    send_cmd(CMD_PUSH,   7'd0,   7'd127, 7'd0);    // re-push of a lone top note
    send_cmd(CMD_PUSH,   7'd127, 7'd85,  7'd127);
    send_cmd(CMD_PUSH,   7'd64,  7'd42,  7'd1);
    send_cmd(CMD_READ,   7'd0,   7'd0,   7'd0);    // zero count gives status only
    send_cmd(CMD_READ,   7'd127, 7'd127, 7'd127);  // count saturates
    send_cmd(CMD_PUSH,   7'd127, 7'd1,   7'd0);    // re-push from the middle
    send_cmd(CMD_REMOVE, 7'd99,  7'd0,   7'd0);    // not held
    idle_burst();
    send_cmd(CMD_REMOVE, 7'd64,  7'd0,   7'd0);
    send_cmd(CMD_READ,   7'd0,   7'd0,   7'd2);
    send_cmd(CMD_REMOVE, 7'd0,   7'd0,   7'd0);
    send_cmd(CMD_REMOVE, 7'd127, 7'd0,   7'd0);
    send_cmd(CMD_REMOVE, 7'd127, 7'd0,   7'd0);
    send_cmd(CMD_PUSH,   7'd33,  7'd127, 7'd64);
    send_cmd(CMD_PUSH,   7'd94,  7'd85,  7'd65);
    send_cmd(CMD_PUSH,   7'd1,   7'd42,  7'd3);
    send_cmd(CMD_READ,   7'd0,   7'd0,   7'd2);    // stops at count mid-stack
    send_cmd(CMD_CLEAR,  7'd0,   7'd0,   7'd0);
    send_cmd(CMD_READ,   7'd0,   7'd0,   7'd1);
    send_cmd(CMD_PUSH,   7'd33,  7'd17,  7'd0);    // held flags were cleared
    send_cmd(CMD_READ,   7'd0,   7'd0,   7'd64);
    send_cmd(CMD_READ,   7'd0,   7'd0,   7'd65);
    drain_results();

    for (int unsigned k = 0; k < RANDOM_CMDS; k++) begin
      if (k == RANDOM_CMDS - CALM_CMDS) tail_calm = 1'b1;
      if (k == RANDOM_CMDS / 2) drain_results();
      if (!tail_calm && $urandom_range(0, 3) == 0) idle_burst();
      random_cmd();
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/nps_pkg.sv
hw/rtl/nps_ram.sv
hw/rtl/nps_ctrl.sv
hw/rtl/note_priority_stack.sv
tb/note_priority_stack_tb.sv
